@@ sv/imm_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and helpers of the integer matrix multiply core.
package imm_pkg;

	localparam int MAX_DIM     = 8;
	localparam int FIELD_LIMIT = 8;
	localparam int DIM_LIMIT   = (MAX_DIM < FIELD_LIMIT) ? MAX_DIM : FIELD_LIMIT;
	localparam int DATA_W      = 32;
	localparam int IDX_W       = 3;
	localparam int DIM_W       = 4;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int DEPTH       = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = $clog2(DEPTH);

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_A = 2'd0,
		MODE_LOAD_B = 2'd1,
		MODE_START  = 2'd2
	} imm_mode_t;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd2;

	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             rd_valid;
		logic             rd_first;
		logic             rd_lastk;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [IDX_W-1:0] k;
		logic             last_elem;
	} imm_cmd_t;

	typedef struct packed {
		logic result_done;
		logic out_free;
	} imm_stat_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > DIM_LIMIT) begin
			r = DIM_W'(DIM_LIMIT);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ sv/imm_in_if.sv @@
`timescale 1ns / 1ps
// Request channel carrying load and start requests into the core.
interface imm_in_if;
	logic                                  valid;
	logic                                  ready;
	logic [imm_pkg::MODE_W-1:0]            mode;
	logic [imm_pkg::IDX_W-1:0]             row_index;
	logic [imm_pkg::IDX_W-1:0]             col_index;
	logic signed [imm_pkg::DATA_W-1:0]     element_value;

	modport source (output valid, mode, row_index, col_index, element_value, input ready);
	modport sink   (input valid, mode, row_index, col_index, element_value, output ready);
endinterface

@@ sv/imm_out_if.sv @@
`timescale 1ns / 1ps
// Result channel carrying elements of the product matrix out of the core.
interface imm_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [imm_pkg::IDX_W-1:0]             out_row;
	logic [imm_pkg::IDX_W-1:0]             out_col;
	logic signed [imm_pkg::DATA_W-1:0]     product_value;
	logic                                  last;

	modport source (output valid, out_row, out_col, product_value, last, input ready);
	modport sink   (input valid, out_row, out_col, product_value, last, output ready);
endinterface

@@ sv/imm_ctrl.sv @@
`timescale 1ns / 1ps
// Controller: configuration registers, request decode and the element walk state machine.
module imm_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [imm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [imm_pkg::DIM_W-1:0]        cfg_data,
	input  logic                             in_valid,
	input  logic [imm_pkg::MODE_W-1:0]       in_mode,
	output logic                             in_ready,
	output imm_pkg::imm_cmd_t                cmd,
	input  imm_pkg::imm_stat_t               stat
);
	import imm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_HOLD
	} state_t;

	state_t           state_q;
	logic [DIM_W-1:0] row_cfg_q;
	logic [DIM_W-1:0] inner_cfg_q;
	logic [DIM_W-1:0] col_cfg_q;
	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] inner_q;
	logic [DIM_W-1:0] cols_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;
	logic             accept;
	logic             k_end;
	logic             j_end;
	logic             i_end;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign k_end    = ({1'b0, k_q} == inner_q - DIM_W'(1));
	assign j_end    = ({1'b0, j_q} == cols_q - DIM_W'(1));
	assign i_end    = ({1'b0, i_q} == rows_q - DIM_W'(1));

	always_comb begin
		cmd           = '0;
		cmd.wr_a      = accept && (in_mode == MODE_LOAD_A);
		cmd.wr_b      = accept && (in_mode == MODE_LOAD_B);
		cmd.rd_valid  = (state_q == ST_ISSUE);
		cmd.rd_first  = (k_q == '0);
		cmd.rd_lastk  = k_end;
		cmd.row       = i_q;
		cmd.col       = j_q;
		cmd.k         = k_q;
		cmd.last_elem = i_end && j_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_cfg_q   <= DIM_W'(8);
			inner_cfg_q <= DIM_W'(8);
			col_cfg_q   <= DIM_W'(8);
			rows_q      <= DIM_W'(1);
			inner_q     <= DIM_W'(1);
			cols_q      <= DIM_W'(1);
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROW_COUNT:   row_cfg_q   <= cfg_data;
					REG_INNER_COUNT: inner_cfg_q <= cfg_data;
					REG_COL_COUNT:   col_cfg_q   <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_mode == MODE_START)) begin
						rows_q  <= eff_dim(row_cfg_q);
						inner_q <= eff_dim(inner_cfg_q);
						cols_q  <= eff_dim(col_cfg_q);
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_end) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_WAIT: begin
					if (stat.result_done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (stat.out_free) begin
						if (i_end && j_end) begin
							state_q <= ST_IDLE;
						end else begin
							if (j_end) begin
								j_q <= '0;
								i_q <= i_q + IDX_W'(1);
							end else begin
								j_q <= j_q + IDX_W'(1);
							end
							state_q <= ST_ISSUE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ sv/imm_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: operand stores, multiply and accumulate pipeline and the result register.
module imm_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  imm_pkg::imm_cmd_t                cmd,
	output imm_pkg::imm_stat_t               stat,
	input  logic [imm_pkg::IDX_W-1:0]        wr_row,
	input  logic [imm_pkg::IDX_W-1:0]        wr_col,
	input  logic [imm_pkg::DATA_W-1:0]       wr_value,
	imm_out_if.source                        result
);
	import imm_pkg::*;

	logic [DATA_W-1:0] store_a_q [DEPTH];
	logic [DATA_W-1:0] store_b_q [DEPTH];
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic              wr_in_range;

	logic [DATA_W-1:0] a_s1;
	logic [DATA_W-1:0] b_s1;
	logic              valid_s1;
	logic              first_s1;
	logic              lastk_s1;
	logic [DATA_W-1:0] prod_s2;
	logic              valid_s2;
	logic              first_s2;
	logic              lastk_s2;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] acc_next;

	logic              out_valid_q;
	logic [IDX_W-1:0]  out_row_q;
	logic [IDX_W-1:0]  out_col_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_last_q;
	logic              load_out;

	assign wr_in_range = (32'(wr_row) < MAX_DIM) && (32'(wr_col) < MAX_DIM);
	assign wr_addr     = ADDR_W'(32'(wr_row) * MAX_DIM + 32'(wr_col));
	assign rd_addr_a   = ADDR_W'(32'(cmd.row) * MAX_DIM + 32'(cmd.k));
	assign rd_addr_b   = ADDR_W'(32'(cmd.k) * MAX_DIM + 32'(cmd.col));

	always_ff @(posedge clk) begin
		if (cmd.wr_a && wr_in_range) begin
			store_a_q[wr_addr] <= wr_value;
		end
		if (cmd.wr_b && wr_in_range) begin
			store_b_q[wr_addr] <= wr_value;
		end
		a_s1    <= store_a_q[rd_addr_a];
		b_s1    <= store_b_q[rd_addr_b];
		prod_s2 <= a_s1 * b_s1;
	end

	assign acc_next = first_s2 ? prod_s2 : acc_q + prod_s2;
	assign load_out = valid_s2 && lastk_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			first_s1    <= 1'b0;
			lastk_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			first_s2    <= 1'b0;
			lastk_s2    <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_valid;
			first_s1 <= cmd.rd_first;
			lastk_s1 <= cmd.rd_lastk;
			valid_s2 <= valid_s1;
			first_s2 <= first_s1;
			lastk_s2 <= lastk_s1;
			if (valid_s2) begin
				acc_q <= acc_next;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_row_q  <= cmd.row;
			out_col_q  <= cmd.col;
			out_data_q <= acc_next;
			out_last_q <= cmd.last_elem;
		end
	end

	assign stat.result_done = load_out;
	assign stat.out_free    = !out_valid_q || result.ready;

	assign result.valid         = out_valid_q;
	assign result.out_row       = out_row_q;
	assign result.out_col       = out_col_q;
	assign result.product_value = out_data_q;
	assign result.last          = out_last_q;

endmodule

@@ sv/integer_matrix_multiply_core.sv @@
`timescale 1ns / 1ps
// Top level of the integer matrix multiply core.
// The item channel takes load requests (mode 0 writes an element of A, mode 1
// an element of B, at row_index and col_index) and start requests (mode 2).
// Loads give no result and are taken one per cycle while the core is idle.
// A start walks C = A * B in row-major order and sends one request per element
// on the result channel, with last set on the final element of C.
// Each element is computed one term per cycle on the single multiply-accumulate unit,
// fed by one read port on each operand store; the terms pass through the operand
// read and product registers before they are accumulated, and the next element
// is issued only once the previous result has entered the result register.
// While a product is being computed the item channel is not ready.
// When the receiver stalls, the result register holds its element and the walk
// pauses before the next element; nothing is lost. Reset returns the core to idle
// and sets all three dimension registers to 8; the operand stores keep no reset
// value and must be loaded before use. The user must write the dimension registers
// through cfg_we, cfg_index and cfg_data only while idle; the core does not check it.
module integer_matrix_multiply_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [imm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [imm_pkg::DIM_W-1:0]        cfg_data,
	imm_in_if.sink                           item,
	imm_out_if.source                        result
);
	import imm_pkg::*;

	imm_cmd_t  cmd;
	imm_stat_t stat;

	imm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (item.valid),
		.in_mode   (item.mode),
		.in_ready  (item.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	imm_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.wr_row   (item.row_index),
		.wr_col   (item.col_index),
		.wr_value (item.element_value),
		.result   (result)
	);

endmodule

@@ sv/imm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the integer matrix multiply core and its bind statement.
module imm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input logic [imm_pkg::MODE_W-1:0]    item_mode,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic                          result_last
);
	import imm_pkg::*;

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result request dropped before it was taken");

	a_busy_while_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !item_ready)
		else $error("item channel ready while a result is pending");

	a_start_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_mode == MODE_START) |=> !item_ready)
		else $error("core still ready after taking a start request");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && result_last |=> item_ready)
		else $error("core not idle after the final result was taken");

	a_busy_mid_product: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && !result_last |=> !item_ready)
		else $error("core became ready before the product was complete");

endmodule

bind integer_matrix_multiply_core imm_checker u_imm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_mode    (item.mode),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_last  (result.last)
);
